>>> hw/rtl/projected_bounding_box_macros.svh
// ---------------------------------------------------------------------------
// projected_bounding_box assertion macros
// shared concurrent assertion forms for the block checker
// ---------------------------------------------------------------------------
`ifndef PROJECTED_BOUNDING_BOX_MACROS_SVH
`define PROJECTED_BOUNDING_BOX_MACROS_SVH

// implication in the same cycle
`define PBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("projected_bounding_box check failed");

// implication on the following cycle
`define PBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("projected_bounding_box check failed");

`endif

>>> hw/rtl/pbb_pkg.sv
// ---------------------------------------------------------------------------
// pbb_pkg
// types, codes and constants shared by the bounding box block
// ---------------------------------------------------------------------------
`default_nettype none
package pbb_pkg;

    localparam int NUM_COEFF   = 21;
    localparam int K_BASE      = 0;
    localparam int R_BASE      = 9;
    localparam int T_BASE      = 18;
    localparam int VERT_FRAC   = 16;
    localparam int MAG_BITS    = 47;
    localparam int ACC_C_W     = 52;
    localparam int PIX_W       = 48;

    localparam logic [11:0] WIDTH_RESET  = 12'd1920;
    localparam logic [11:0] HEIGHT_RESET = 12'd1080;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_VERTEX = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_R,
        S_DRAIN_R,
        S_MUL_K,
        S_DRAIN_K,
        S_CHECK,
        S_MUL_S,
        S_DRAIN_S,
        S_DIV_INIT,
        S_DIV,
        S_UPDATE,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CAPTURE,
        OP_MUL_R,
        OP_MUL_K,
        OP_MAG,
        OP_MUL_S,
        OP_DIV_INIT,
        OP_DIV,
        OP_UPDATE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] step;
    } cmd_t;

    typedef struct packed {
        logic zero_depth;
        logic last;
        logic out_free;
    } status_t;

    function automatic logic [1:0] step_row(input logic [3:0] s);
        logic [1:0] r;
        unique case (s)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] step_col(input logic [3:0] s);
        logic [1:0] c;
        unique case (s)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            4'd2, 4'd5, 4'd8: c = 2'd2;
            default:          c = 2'd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pbb_in_if.sv
// ---------------------------------------------------------------------------
// pbb_in_if
// request channel carrying coefficient loads and vertices
// ---------------------------------------------------------------------------
`default_nettype none
interface pbb_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [4:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic               is_last_vertex;

    modport source (
        output valid, action, coeff_index, coeff_value,
               vertex_x, vertex_y, vertex_z, is_last_vertex,
        input  ready
    );
    modport sink (
        input  valid, action, coeff_index, coeff_value,
               vertex_x, vertex_y, vertex_z, is_last_vertex,
        output ready
    );
endinterface
`default_nettype wire

>>> hw/rtl/pbb_out_if.sv
// ---------------------------------------------------------------------------
// pbb_out_if
// result channel carrying one bounding box per mesh
// ---------------------------------------------------------------------------
`default_nettype none
interface pbb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] box_min_x;
    logic [15:0] box_min_y;
    logic [15:0] box_max_x;
    logic [15:0] box_max_y;
    logic        on_screen;
    logic        depth_error;

    modport source (
        output valid, box_min_x, box_min_y, box_max_x, box_max_y,
               on_screen, depth_error,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_max_x, box_max_y,
               on_screen, depth_error,
        output ready
    );
endinterface
`default_nettype wire

>>> hw/rtl/pbb_ctrl.sv
// ---------------------------------------------------------------------------
// pbb_ctrl
// sequencer for projection, scaling, division and box update
// ---------------------------------------------------------------------------
`default_nettype none
module pbb_ctrl #(
    parameter int COEFF_FRAC_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_action,
    output logic                  in_ready,
    input  wire pbb_pkg::status_t status,
    output pbb_pkg::cmd_t         cmd
);
    localparam int PW   = 66 - COEFF_FRAC_BITS;
    localparam int NW   = PW + 16;
    localparam int CNTW = $clog2(NW);

    pbb_pkg::state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbb_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = pbb_pkg::OP_NOP;
        cmd.step   = 4'(cnt_reg);
        in_ready   = 1'b0;
        unique case (state_reg)
            pbb_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
                if (in_valid)
                begin
                    if (in_action == pbb_pkg::ACT_VERTEX)
                    begin
                        cmd.op     = pbb_pkg::OP_CAPTURE;
                        state_next = pbb_pkg::S_MUL_R;
                    end
                    else
                    begin
                        cmd.op = pbb_pkg::OP_LOAD;
                    end
                end
            end
            pbb_pkg::S_MUL_R:
            begin
                cmd.op = pbb_pkg::OP_MUL_R;
                if (cnt_reg == CNTW'(8))
                begin
                    cnt_next   = '0;
                    state_next = pbb_pkg::S_DRAIN_R;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pbb_pkg::S_DRAIN_R:
            begin
                state_next = pbb_pkg::S_MUL_K;
            end
            pbb_pkg::S_MUL_K:
            begin
                cmd.op = pbb_pkg::OP_MUL_K;
                if (cnt_reg == CNTW'(8))
                begin
                    cnt_next   = '0;
                    state_next = pbb_pkg::S_DRAIN_K;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pbb_pkg::S_DRAIN_K:
            begin
                state_next = pbb_pkg::S_CHECK;
            end
            pbb_pkg::S_CHECK:
            begin
                cmd.op = pbb_pkg::OP_MAG;
                if (status.zero_depth)
                    state_next = pbb_pkg::S_UPDATE;
                else
                    state_next = pbb_pkg::S_MUL_S;
            end
            pbb_pkg::S_MUL_S:
            begin
                cmd.op = pbb_pkg::OP_MUL_S;
                if (cnt_reg == CNTW'(3))
                begin
                    cnt_next   = '0;
                    state_next = pbb_pkg::S_DRAIN_S;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pbb_pkg::S_DRAIN_S:
            begin
                state_next = pbb_pkg::S_DIV_INIT;
            end
            pbb_pkg::S_DIV_INIT:
            begin
                cmd.op     = pbb_pkg::OP_DIV_INIT;
                cnt_next   = '0;
                state_next = pbb_pkg::S_DIV;
            end
            pbb_pkg::S_DIV:
            begin
                cmd.op = pbb_pkg::OP_DIV;
                if (cnt_reg == CNTW'(NW - 1))
                begin
                    cnt_next   = '0;
                    state_next = pbb_pkg::S_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pbb_pkg::S_UPDATE:
            begin
                cmd.op = pbb_pkg::OP_UPDATE;
                if (status.last)
                    state_next = pbb_pkg::S_EMIT;
                else
                    state_next = pbb_pkg::S_IDLE;
            end
            pbb_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = pbb_pkg::OP_EMIT;
                    state_next = pbb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pbb_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> hw/rtl/pbb_datapath.sv
// ---------------------------------------------------------------------------
// pbb_datapath
// coefficient store, shared multiplier, divider and running box
// ---------------------------------------------------------------------------
`default_nettype none
module pbb_datapath #(
    parameter int COEFF_FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pbb_pkg::cmd_t      cmd,
    output pbb_pkg::status_t        status,
    input  wire logic [4:0]         coeff_index,
    input  wire logic signed [31:0] coeff_value,
    input  wire logic signed [31:0] vertex_x,
    input  wire logic signed [31:0] vertex_y,
    input  wire logic signed [31:0] vertex_z,
    input  wire logic               is_last_vertex,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [11:0]        cfg_data,
    pbb_out_if.source               out_ch
);
    localparam int F  = COEFF_FRAC_BITS;
    localparam int PW = 66 - F;
    localparam int NW = PW + 16;
    localparam int CW = pbb_pkg::ACC_C_W;
    localparam int XW = pbb_pkg::PIX_W;

    logic signed [31:0]  coef_reg [pbb_pkg::NUM_COEFF];
    logic signed [31:0]  v_reg [3];
    logic                last_reg;
    logic [11:0]         width_reg, height_reg;

    logic signed [65:0]  prod_reg;
    logic                tag_valid_reg;
    pbb_pkg::cmd_t       tag_reg;

    logic signed [CW-1:0] acc_c_reg [3];
    logic signed [PW-1:0] acc_p_reg [3];
    logic [PW-1:0]        mag_x_reg, mag_y_reg, mag_d_reg;
    logic                 neg_x_reg, neg_y_reg;
    logic [NW-1:0]        nx_reg, ny_reg;
    logic [NW-1:0]        qx_reg, qy_reg;
    logic [PW:0]          rx_reg, ry_reg;

    logic signed [XW-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic                 seen_reg, derr_reg;

    logic                 out_valid_reg, on_screen_reg, derr_out_reg;
    logic [15:0]          bminx_reg, bminy_reg, bmaxx_reg, bmaxy_reg;

    logic signed [31:0]   c_sat [3];
    logic [1:0]           col, tag_row;
    logic signed [32:0]   ma, mb;
    logic signed [65:0]   prod;
    logic [4:0]           cidx;
    logic [15:0]          wscale, hscale;

    logic [PW:0]          rx_sh, ry_sh, dext;
    logic                 gex, gey;
    logic [PW:0]          rx_next, ry_next;
    logic [NW-1:0]        qx_next, qy_next, nx_next, ny_next;

    logic [XW-1:0]        xm, ym;
    logic signed [XW-1:0] px, py;
    logic signed [XW-1:0] wl, hl;
    logic signed [XW-1:0] ca, cb, cc, cd;
    logic                 visible;
    logic                 zero_depth;

    assign wscale = {width_reg, 4'd0};
    assign hscale = {height_reg, 4'd0};
    assign col    = pbb_pkg::step_col(cmd.step);
    assign tag_row = pbb_pkg::step_row(tag_reg.step);
    assign zero_depth = (acc_p_reg[2] == '0);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if ((&acc_c_reg[j][CW-1:31]) || !(|acc_c_reg[j][CW-1:31]))
                c_sat[j] = acc_c_reg[j][31:0];
            else if (acc_c_reg[j][CW-1])
                c_sat[j] = 32'sh8000_0000;
            else
                c_sat[j] = 32'sh7FFF_FFFF;
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        ma   = '0;
        mb   = '0;
        cidx = '0;
        case (cmd.op)
            pbb_pkg::OP_MUL_R:
            begin
                cidx = 5'(pbb_pkg::R_BASE) + 5'(cmd.step);
                ma   = {coef_reg[cidx][31], coef_reg[cidx]};
                mb   = {v_reg[col][31], v_reg[col]};
            end
            pbb_pkg::OP_MUL_K:
            begin
                cidx = 5'(pbb_pkg::K_BASE) + 5'(cmd.step);
                ma   = {coef_reg[cidx][31], coef_reg[cidx]};
                mb   = {c_sat[col][31], c_sat[col]};
            end
            pbb_pkg::OP_MUL_S:
            begin
                if (!cmd.step[1])
                begin
                    ma = cmd.step[0] ? 33'(mag_x_reg[PW-1:32]) : {1'b0, mag_x_reg[31:0]};
                    mb = {17'd0, wscale};
                end
                else
                begin
                    ma = cmd.step[0] ? 33'(mag_y_reg[PW-1:32]) : {1'b0, mag_y_reg[31:0]};
                    mb = {17'd0, hscale};
                end
            end
            default:
            begin
                ma = '0;
            end
        endcase
    end

    assign prod = ma * mb;

    // one quotient bit per cycle for x and y against the shared depth
    always_comb
    begin
        dext    = {1'b0, mag_d_reg};
        rx_sh   = {rx_reg[PW-1:0], nx_reg[NW-1]};
        ry_sh   = {ry_reg[PW-1:0], ny_reg[NW-1]};
        gex     = (rx_sh >= dext);
        gey     = (ry_sh >= dext);
        rx_next = gex ? rx_sh - dext : rx_sh;
        ry_next = gey ? ry_sh - dext : ry_sh;
        qx_next = {qx_reg[NW-2:0], gex};
        qy_next = {qy_reg[NW-2:0], gey};
        nx_next = {nx_reg[NW-2:0], 1'b0};
        ny_next = {ny_reg[NW-2:0], 1'b0};
    end

    always_comb
    begin
        xm = (|qx_reg[NW-1:pbb_pkg::MAG_BITS]) ? {1'b0, {pbb_pkg::MAG_BITS{1'b1}}}
                                                : {1'b0, qx_reg[pbb_pkg::MAG_BITS-1:0]};
        ym = (|qy_reg[NW-1:pbb_pkg::MAG_BITS]) ? {1'b0, {pbb_pkg::MAG_BITS{1'b1}}}
                                                : {1'b0, qy_reg[pbb_pkg::MAG_BITS-1:0]};
        px = neg_x_reg ? -$signed(xm) : $signed(xm);
        py = neg_y_reg ? -$signed(ym) : $signed(ym);
    end

    always_comb
    begin
        wl = $signed({32'd0, wscale});
        hl = $signed({32'd0, hscale});
        visible = seen_reg && !(max_x_reg < 0 || max_y_reg < 0 ||
                                min_x_reg >= wl || min_y_reg >= hl);
        ca = (min_x_reg > 0) ? min_x_reg : '0;
        cb = (min_y_reg > 0) ? min_y_reg : '0;
        cc = (max_x_reg < wl) ? max_x_reg : wl;
        cd = (max_y_reg < hl) ? max_y_reg : hl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pbb_pkg::NUM_COEFF; i++)
                coef_reg[i] <= '0;
            width_reg     <= pbb_pkg::WIDTH_RESET;
            height_reg    <= pbb_pkg::HEIGHT_RESET;
            tag_valid_reg <= 1'b0;
            min_x_reg     <= '0;
            min_y_reg     <= '0;
            max_x_reg     <= '0;
            max_y_reg     <= '0;
            seen_reg      <= 1'b0;
            derr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pbb_pkg::CFG_IMAGE_WIDTH)
                    width_reg <= cfg_data;
                else if (cfg_index == pbb_pkg::CFG_IMAGE_HEIGHT)
                    height_reg <= cfg_data;
            end
            if (cmd.op == pbb_pkg::OP_LOAD && coeff_index < 5'(pbb_pkg::NUM_COEFF))
                coef_reg[coeff_index] <= coeff_value;
            tag_valid_reg <= (cmd.op == pbb_pkg::OP_MUL_R) ||
                             (cmd.op == pbb_pkg::OP_MUL_K) ||
                             (cmd.op == pbb_pkg::OP_MUL_S);
            if (cmd.op == pbb_pkg::OP_UPDATE)
            begin
                if (zero_depth)
                begin
                    derr_reg <= 1'b1;
                end
                else if (!seen_reg)
                begin
                    min_x_reg <= px;
                    max_x_reg <= px;
                    min_y_reg <= py;
                    max_y_reg <= py;
                    seen_reg  <= 1'b1;
                end
                else
                begin
                    if (px < min_x_reg) min_x_reg <= px;
                    if (px > max_x_reg) max_x_reg <= px;
                    if (py < min_y_reg) min_y_reg <= py;
                    if (py > max_y_reg) max_y_reg <= py;
                end
            end
            if (cmd.op == pbb_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
                min_x_reg     <= '0;
                min_y_reg     <= '0;
                max_x_reg     <= '0;
                max_y_reg     <= '0;
                seen_reg      <= 1'b0;
                derr_reg      <= 1'b0;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        tag_reg  <= cmd;
        if (cmd.op == pbb_pkg::OP_CAPTURE)
        begin
            v_reg[0] <= vertex_x;
            v_reg[1] <= vertex_y;
            v_reg[2] <= vertex_z;
            last_reg <= is_last_vertex;
            for (int i = 0; i < 3; i++)
            begin
                acc_c_reg[i] <= CW'(coef_reg[pbb_pkg::T_BASE + i]);
                acc_p_reg[i] <= '0;
            end
            nx_reg <= '0;
            ny_reg <= '0;
        end
        if (tag_valid_reg)
        begin
            case (tag_reg.op)
                pbb_pkg::OP_MUL_R:
                    acc_c_reg[tag_row] <= acc_c_reg[tag_row]
                                          + CW'(prod_reg >>> pbb_pkg::VERT_FRAC);
                pbb_pkg::OP_MUL_K:
                    acc_p_reg[tag_row] <= acc_p_reg[tag_row] + PW'(prod_reg >>> F);
                pbb_pkg::OP_MUL_S:
                begin
                    if (!tag_reg.step[1])
                        nx_reg <= nx_reg + (tag_reg.step[0] ? {prod_reg[NW-33:0], 32'd0}
                                                            : NW'(prod_reg));
                    else
                        ny_reg <= ny_reg + (tag_reg.step[0] ? {prod_reg[NW-33:0], 32'd0}
                                                            : NW'(prod_reg));
                end
                default:
                begin
                    nx_reg <= nx_reg;
                end
            endcase
        end
        if (cmd.op == pbb_pkg::OP_MAG)
        begin
            mag_x_reg <= acc_p_reg[0][PW-1] ? PW'(-acc_p_reg[0]) : PW'(acc_p_reg[0]);
            mag_y_reg <= acc_p_reg[1][PW-1] ? PW'(-acc_p_reg[1]) : PW'(acc_p_reg[1]);
            mag_d_reg <= acc_p_reg[2][PW-1] ? PW'(-acc_p_reg[2]) : PW'(acc_p_reg[2]);
            neg_x_reg <= acc_p_reg[0][PW-1] ^ acc_p_reg[2][PW-1];
            neg_y_reg <= acc_p_reg[1][PW-1] ^ acc_p_reg[2][PW-1];
        end
        if (cmd.op == pbb_pkg::OP_DIV_INIT)
        begin
            rx_reg <= '0;
            ry_reg <= '0;
            qx_reg <= '0;
            qy_reg <= '0;
        end
        if (cmd.op == pbb_pkg::OP_DIV)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            nx_reg <= nx_next;
            ny_reg <= ny_next;
        end
        if (cmd.op == pbb_pkg::OP_EMIT)
        begin
            derr_out_reg  <= derr_reg;
            on_screen_reg <= visible;
            bminx_reg     <= visible ? ca[15:0] : 16'd0;
            bminy_reg     <= visible ? cb[15:0] : 16'd0;
            bmaxx_reg     <= visible ? cc[15:0] : 16'd0;
            bmaxy_reg     <= visible ? cd[15:0] : 16'd0;
        end
    end

    assign status.zero_depth = zero_depth;
    assign status.last       = last_reg;
    assign status.out_free   = !out_valid_reg || out_ch.ready;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.box_min_x   = bminx_reg;
    assign out_ch.box_min_y   = bminy_reg;
    assign out_ch.box_max_x   = bmaxx_reg;
    assign out_ch.box_max_y   = bmaxy_reg;
    assign out_ch.on_screen   = on_screen_reg;
    assign out_ch.depth_error = derr_out_reg;
endmodule
`default_nettype wire

>>> hw/rtl/projected_bounding_box.sv
// ---------------------------------------------------------------------------
// projected_bounding_box
// screen-space bounding box of a vertex stream through one pinhole camera
// ---------------------------------------------------------------------------
// A vertex passes through the one shared 33x33 multiplier (22 products per
// vertex) and through the divider of NW = 82 - COEFF_FRAC_BITS (66 at the
// default) quotient bits, which yields one quotient bit of x and y per cycle;
// a zero-depth vertex skips the scaling and the division, and the last vertex
// of a mesh adds an emit step. The box request waits in an output register
// while the next vertex is taken.
`default_nettype none
module projected_bounding_box #(
    parameter int COEFF_FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pbb_in_if.sink           in_ch,
    pbb_out_if.source        out_ch,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);
    pbb_pkg::cmd_t    cmd;
    pbb_pkg::status_t status;
    logic             ready_w;

    assign in_ch.ready = ready_w;

    pbb_ctrl #(
        .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_action(in_ch.action),
        .in_ready (ready_w),
        .status   (status),
        .cmd      (cmd)
    );

    pbb_datapath #(
        .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .coeff_index   (in_ch.coeff_index),
        .coeff_value   (in_ch.coeff_value),
        .vertex_x      (in_ch.vertex_x),
        .vertex_y      (in_ch.vertex_y),
        .vertex_z      (in_ch.vertex_z),
        .is_last_vertex(in_ch.is_last_vertex),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ch        (out_ch)
    );
endmodule
`default_nettype wire

>>> hw/rtl/pbb_checker.sv
// ---------------------------------------------------------------------------
// pbb_checker
// port-level checks of the bounding box block
// ---------------------------------------------------------------------------
`default_nettype none
`include "projected_bounding_box_macros.svh"
module pbb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_action,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] box_min_x,
    input wire logic [15:0] box_min_y,
    input wire logic [15:0] box_max_x,
    input wire logic [15:0] box_max_y,
    input wire logic        on_screen,
    input wire logic        depth_error
);
    `PBB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(box_min_x) && $stable(box_max_x) && $stable(box_min_y) && $stable(box_max_y) && $stable(on_screen) && $stable(depth_error))
    `PBB_ASSERT_NOW(a_off_zero, clk, rst_n, out_valid && !on_screen, box_min_x == 16'd0 && box_min_y == 16'd0 && box_max_x == 16'd0 && box_max_y == 16'd0)
    `PBB_ASSERT_NOW(a_order, clk, rst_n, out_valid && on_screen, box_min_x <= box_max_x && box_min_y <= box_max_y)
    `PBB_ASSERT_NEXT(a_vertex_busy, clk, rst_n, in_valid && in_ready && in_action, !in_ready)
endmodule

bind projected_bounding_box pbb_checker u_pbb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_action  (in_ch.action),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .box_min_x  (out_ch.box_min_x),
    .box_min_y  (out_ch.box_min_y),
    .box_max_x  (out_ch.box_max_x),
    .box_max_y  (out_ch.box_max_y),
    .on_screen  (out_ch.on_screen),
    .depth_error(out_ch.depth_error)
);
`default_nettype wire

>>> tb/pbb_box_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbb_box_checker
// watches the request and box channels and the register port, keeps its own
// model of the camera and the running box, and compares every box request
// ---------------------------------------------------------------------------
`default_nettype none
module pbb_box_checker
    import pbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    pbb_in_if.sink           in_mon,
    pbb_out_if.sink          out_mon,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data,
    output int               errors,
    output int               pending
);

    localparam longint PIX_SAT = 64'h0000_7FFF_FFFF_FFFF;

    typedef struct packed {
        logic [15:0] min_x;
        logic [15:0] min_y;
        logic [15:0] max_x;
        logic [15:0] max_y;
        logic        on_screen;
        logic        depth_error;
    } box_t;

    logic signed [31:0] cam [NUM_COEFF];
    logic [11:0]        width_px;
    logic [11:0]        height_px;
    longint             lo_x, lo_y, hi_x, hi_y;
    logic               any_vertex;
    logic               zero_depth_seen;
    box_t               box_q [$];

    assign pending = box_q.size();

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint pixel_ratio(input longint num, input longint den,
                                           input logic [15:0] scale);
        logic [127:0] prod;
        logic [127:0] dmag;
        logic [127:0] quo;
        longint       m;
        prod = 128'(num < 0 ? -num : num) * 128'(scale);
        dmag = 128'(den < 0 ? -den : den);
        quo  = prod / dmag;
        m    = (quo >= 128'h8000_0000_0000) ? PIX_SAT : longint'(quo[63:0]);
        return ((num < 0) != (den < 0)) ? -m : m;
    endfunction

    function automatic logic project_vertex(input longint vtx [3],
                                            output longint px, output longint py);
        longint cc [3];
        longint pp [3];
        longint s;
        for (int i = 0; i < 3; i++)
        begin
            s = longint'(cam[T_BASE + i]);
            for (int j = 0; j < 3; j++)
                s += (longint'(cam[R_BASE + 3 * i + j]) * vtx[j]) >>> VERT_FRAC;
            cc[i] = sat_word(s);
        end
        for (int i = 0; i < 3; i++)
        begin
            s = 0;
            for (int j = 0; j < 3; j++)
                s += (longint'(cam[K_BASE + 3 * i + j]) * cc[j]) >>> 16;
            pp[i] = s;
        end
        px = 0;
        py = 0;
        if (pp[2] == 0)
            return 1'b0;
        px = pixel_ratio(pp[0], pp[2], {width_px, 4'd0});
        py = pixel_ratio(pp[1], pp[2], {height_px, 4'd0});
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        longint vtx [3];
        longint px, py, wl, hl;
        box_t   bx;
        box_t   got;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFF; i++)
                cam[i] = '0;
            width_px        = WIDTH_RESET;
            height_px       = HEIGHT_RESET;
            lo_x            = 0;
            lo_y            = 0;
            hi_x            = 0;
            hi_y            = 0;
            any_vertex      = 1'b0;
            zero_depth_seen = 1'b0;
            errors          = 0;
            box_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_IMAGE_WIDTH)
                    width_px = cfg_data;
                else if (cfg_index == CFG_IMAGE_HEIGHT)
                    height_px = cfg_data;
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got = {out_mon.box_min_x, out_mon.box_min_y, out_mon.box_max_x,
                       out_mon.box_max_y, out_mon.on_screen, out_mon.depth_error};
                if (box_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected box request %h", $time, got);
                end
                else
                begin
                    bx = box_q.pop_front();
                    if (got.min_x != bx.min_x)
                    begin
                        errors++;
                        $display("%0t: box_min_x exp %h got %h", $time, bx.min_x, got.min_x);
                    end
                    if (got.min_y != bx.min_y)
                    begin
                        errors++;
                        $display("%0t: box_min_y exp %h got %h", $time, bx.min_y, got.min_y);
                    end
                    if (got.max_x != bx.max_x)
                    begin
                        errors++;
                        $display("%0t: box_max_x exp %h got %h", $time, bx.max_x, got.max_x);
                    end
                    if (got.max_y != bx.max_y)
                    begin
                        errors++;
                        $display("%0t: box_max_y exp %h got %h", $time, bx.max_y, got.max_y);
                    end
                    if (got.on_screen != bx.on_screen)
                    begin
                        errors++;
                        $display("%0t: on_screen exp %b got %b", $time,
                                 bx.on_screen, got.on_screen);
                    end
                    if (got.depth_error != bx.depth_error)
                    begin
                        errors++;
                        $display("%0t: depth_error exp %b got %b", $time,
                                 bx.depth_error, got.depth_error);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.action == ACT_LOAD)
                begin
                    if (in_mon.coeff_index < NUM_COEFF)
                        cam[in_mon.coeff_index] = in_mon.coeff_value;
                end
                else
                begin
                    vtx[0] = longint'(in_mon.vertex_x);
                    vtx[1] = longint'(in_mon.vertex_y);
                    vtx[2] = longint'(in_mon.vertex_z);
                    if (project_vertex(vtx, px, py))
                    begin
                        if (!any_vertex)
                        begin
                            lo_x = px;
                            hi_x = px;
                            lo_y = py;
                            hi_y = py;
                            any_vertex = 1'b1;
                        end
                        else
                        begin
                            if (px < lo_x) lo_x = px;
                            if (px > hi_x) hi_x = px;
                            if (py < lo_y) lo_y = py;
                            if (py > hi_y) hi_y = py;
                        end
                    end
                    else
                        zero_depth_seen = 1'b1;
                    if (in_mon.is_last_vertex)
                    begin
                        bx = '0;
                        bx.depth_error = zero_depth_seen;
                        wl = longint'(width_px) * 16;
                        hl = longint'(height_px) * 16;
                        if (any_vertex && !(hi_x < 0 || hi_y < 0 || lo_x >= wl || lo_y >= hl))
                        begin
                            bx.min_x     = 16'(lo_x > 0 ? lo_x : 0);
                            bx.min_y     = 16'(lo_y > 0 ? lo_y : 0);
                            bx.max_x     = 16'(hi_x < wl ? hi_x : wl);
                            bx.max_y     = 16'(hi_y < hl ? hi_y : hl);
                            bx.on_screen = 1'b1;
                        end
                        box_q = {box_q, bx};
                        lo_x = 0;
                        lo_y = 0;
                        hi_x = 0;
                        hi_y = 0;
                        any_vertex      = 1'b0;
                        zero_depth_seen = 1'b0;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> tb/tb_projected_bounding_box.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_projected_bounding_box
// drives camera loads, vertex meshes and register writes into the block,
// with random gaps and back-pressure; the checker predicts each box
// ---------------------------------------------------------------------------
`default_nettype none
module tb_projected_bounding_box;
    import pbb_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 160;
    localparam int ONE         = 65536;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        gaps_on;
    int          errors;
    int          pending;
    int          quiet_cycles;

    pbb_in_if  in_ch ();
    pbb_out_if out_ch ();

    projected_bounding_box dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pbb_box_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // vertex depth that tends to cancel the camera offset and hit zero depth
    function automatic int u_tz_guess();
        return $urandom_range(0, 3) == 0 ? 32'($urandom) : 4 * ONE;
    endfunction

    task automatic send_req(input logic act, input logic [4:0] idx, input logic [31:0] val,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic last);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.action         <= act;
        in_ch.coeff_index    <= idx;
        in_ch.coeff_value    <= val;
        in_ch.vertex_x       <= x;
        in_ch.vertex_y       <= y;
        in_ch.vertex_z       <= z;
        in_ch.is_last_vertex <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_vertex(input int x, input int y, input int z, input logic last);
        send_req(ACT_VERTEX, 5'($urandom), $urandom, x, y, z, last);
    endtask

    task automatic send_coeff(input int idx, input int val);
        send_req(ACT_LOAD, 5'(idx), val, $urandom, $urandom, $urandom, 1'($urandom));
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // simple normalized camera: focal f, principal point c, identity-ish pose
    task automatic load_camera(input int fx, input int cx, input int fy, input int cy,
                               input logic tilt, input int tz);
        int kv [9];
        int rv [9];
        kv = '{fx, 0, cx, 0, fy, cy, 0, 0, ONE};
        rv = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        if (tilt)
            for (int i = 0; i < 9; i++)
                rv[i] = rv[i] + $signed($urandom_range(0, 16384)) - 8192;
        for (int i = 0; i < 9; i++)
            send_coeff(K_BASE + i, kv[i]);
        for (int i = 0; i < 9; i++)
            send_coeff(R_BASE + i, rv[i]);
        send_coeff(T_BASE, 0);
        send_coeff(T_BASE + 1, 0);
        send_coeff(T_BASE + 2, tz);
    endtask

    initial
    begin
        int sel;
        int lim;
        rst_n                = 1'b0;
        gaps_on              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.action         = ACT_LOAD;
        in_ch.coeff_index    = '0;
        in_ch.coeff_value    = '0;
        in_ch.vertex_x       = '0;
        in_ch.vertex_y       = '0;
        in_ch.vertex_z       = '0;
        in_ch.is_last_vertex = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mesh on the reset image size, all-zero camera gives zero depth
        send_vertex(0, 0, 0, 1'b1);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 12'd640);
        write_reg(CFG_IMAGE_HEIGHT, 12'd480);
        write_reg(2'd2, 12'd7);
        write_reg(2'd3, 12'hFFF);
        load_camera(ONE / 2, ONE / 2, ONE / 2, ONE / 2, 1'b0, 4 * ONE);
        send_vertex(0, 0, 0, 1'b1);
        send_vertex(ONE, ONE, 0, 1'b0);
        send_vertex(-ONE, -ONE, 0, 1'b1);
        send_vertex(0, 0, -4 * ONE, 1'b1);
        send_vertex(ONE, 0, -8 * ONE, 1'b0);
        send_vertex(0, 0, -4 * ONE, 1'b1);
        send_vertex(20 * ONE, 0, 0, 1'b1);
        send_vertex(0, -30 * ONE, 0, 1'b1);
        send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
        send_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
        send_req(ACT_LOAD, 5'd31, 32'hFFFFFFFF, '0, '0, '0, 1'b1);
        send_req(ACT_LOAD, 5'd21, 32'h80000000, '0, '0, '0, 1'b0);
        send_vertex(ONE / 4, 0, 0, 1'b0);
        send_coeff(T_BASE, ONE);
        send_vertex(ONE / 4, 0, 0, 1'b1);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 12'd0);
        send_vertex(0, 0, 0, 1'b1);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 12'd4095);
        write_reg(CFG_IMAGE_HEIGHT, 12'd4095);
        send_vertex(-ONE, ONE, 0, 1'b0);
        send_vertex(ONE, -ONE, ONE, 1'b1);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 12'd1);
        write_reg(CFG_IMAGE_HEIGHT, 12'd1);
        send_vertex(0, 0, 0, 1'b1);
        wait_idle();

        gaps_on = 1'b1;
        for (int n = 0; n < 270; n++)
        begin
            if (n == 230)
                gaps_on = 1'b0;
            if (n % 80 == 0)
            begin
                wait_idle();
                sel = $urandom_range(0, 3);
                write_reg(CFG_IMAGE_WIDTH, sel == 0 ? 12'd4095 : sel == 1 ? 12'd1 :
                                           12'($urandom_range(1, 4095)));
                write_reg(CFG_IMAGE_HEIGHT, sel == 0 ? 12'd1 : sel == 1 ? 12'd4095 :
                                            12'($urandom_range(1, 4095)));
                load_camera($urandom_range(ONE / 5, 2 * ONE), $urandom_range(0, ONE),
                            $urandom_range(ONE / 5, 2 * ONE), $urandom_range(0, ONE),
                            1'($urandom), $urandom_range(2 * ONE, 10 * ONE));
            end
            if (n == 130)
                wait_idle();
            sel = $urandom_range(0, 19);
            lim = (sel == 0) ? 8 * ONE : 2 * ONE;
            if (sel == 1)
                send_req(1'($urandom), 5'($urandom), $urandom, $urandom, $urandom,
                         $urandom, 1'($urandom));
            else if (sel == 2)
                send_coeff($urandom_range(0, 20), $urandom_range(0, 2 * ONE) - ONE);
            else if (sel == 3)
                send_vertex($urandom_range(0, 2 * ONE) - ONE, $urandom_range(0, 2 * ONE) - ONE,
                            -$signed(32'(u_tz_guess())), 1'($urandom_range(0, 2) == 0));
            else
                send_vertex($urandom_range(0, lim) - lim / 2, $urandom_range(0, lim) - lim / 2,
                            $urandom_range(0, ONE) - ONE / 2, 1'($urandom_range(0, 5) == 0));
        end
        send_vertex(0, 0, 0, 1'b1);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pbb_pkg.sv
hw/rtl/pbb_in_if.sv
hw/rtl/pbb_out_if.sv
hw/rtl/pbb_ctrl.sv
hw/rtl/pbb_datapath.sv
hw/rtl/projected_bounding_box.sv
hw/rtl/pbb_checker.sv
tb/pbb_box_checker.sv
tb/tb_projected_bounding_box.sv
